@@ rtl/ppu_pkg.sv @@
package ppu_pkg;

	// Request codes on the opcode port
	typedef enum logic [1:0] {
		OP_SPAWN = 2'd0,
		OP_TICK  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [1:0] REG_GRAVITY_X = 2'd0;
	localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
	localparam logic [1:0] REG_GRAVITY_Z = 2'd2;

	localparam logic signed [23:0] GRAVITY_Y_RST = -24'sd642908;
	localparam logic signed [31:0] LIFE_DEAD     = -32'sd65536;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SPAWN = 5'b00100,
		ST_TICK  = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

	// One pool entry as held in memory
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [47:0]        colors;
		logic [15:0]        size;
		logic signed [31:0] life;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Saturate a widened sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [31:0] r;
		if (x > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -34'sh0_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/ppu_mem.sv @@
module ppu_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 288
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/particle_pool_update.sv @@
// Channel  | Signals                                           | Handshake
// ---------+---------------------------------------------------+---------------------------
// request  | opcode, pos_*, vel_*, colors, size, life, dt, slot | taken when start & !busy
// result   | accepted, alive, out_pos_*, out_size, rgb, alpha   | done high for one cycle
// config   | cfg_we, cfg_addr, cfg_wdata                        | written when cfg_we is high
//
// Operations: spawn scans the pool one entry a cycle until a free entry or the
// last one; tick streams every entry through a three stage read-modify-write pipe
// on the pool memory's read and write ports; read fetches one entry; an unknown
// opcode or an out of range read answers without touching the pool.
// Reset: a clearing pass writes every entry as dead, with busy high.
// The receiver cannot stall: each result is shown on exactly one done cycle.
module particle_pool_update #(
	parameter int POOL_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [47:0]        colors,
	input  logic [15:0]        size,
	input  logic signed [31:0] life,
	input  logic [15:0]        dt,
	input  logic [9:0]         slot,
	output logic               done,
	output logic               accepted,
	output logic               alive,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic [15:0]        out_size,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [23:0]        cfg_wdata
);

	localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] CNT_END  = CW'(POOL_SLOTS);
	localparam logic [AW-1:0] ADDR_TOP = AW'(POOL_SLOTS - 1);

	ppu_pkg::state_t state_q;
	logic [CW-1:0]   cnt_q;

	logic signed [23:0] grav_x_q, grav_y_q, grav_z_q;
	logic signed [24:0] gdt_x_q, gdt_y_q, gdt_z_q;
	logic [15:0]        dt_q;
	ppu_pkg::slot_t     spw_q;

	// Memory ports
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	ppu_pkg::slot_t             wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [ppu_pkg::SLOT_W-1:0] rd_raw;
	ppu_pkg::slot_t             rw;

	logic          chk_v_q;
	logic [AW-1:0] chk_addr_q;

	// Stage 2 and 3 registers
	logic                v2_q, v3_q;
	ppu_pkg::slot_t      word_s2, word_s3;
	logic                live_s2, live_s3;
	logic [AW-1:0]       addr_s2, addr_s3;
	logic signed [40:0]  prod_r_s2, prod_g_s2, prod_b_s2;
	logic [24:0]         prod_a_s2;
	logic signed [48:0]  prod_x_s3, prod_y_s3, prod_z_s3;

	logic accept, in_range, idle_zero, found, last, spawn_res, tick_end, read_res;
	ppu_pkg::op_t op;

	assign busy     = (state_q != ppu_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign op       = ppu_pkg::op_t'(opcode);
	assign in_range = (32'(slot) < 32'(POOL_SLOTS));
	assign rw       = ppu_pkg::slot_t'(rd_raw);

	assign idle_zero = accept && ((op == ppu_pkg::OP_NONE) ||
		((op == ppu_pkg::OP_READ) && !in_range));
	assign found     = (state_q == ppu_pkg::ST_SPAWN) && chk_v_q && (rw.life <= 32'sd0);
	assign last      = (state_q == ppu_pkg::ST_SPAWN) && chk_v_q && (chk_addr_q == ADDR_TOP);
	assign spawn_res = found || last;
	assign tick_end  = (state_q == ppu_pkg::ST_TICK) && (cnt_q == CNT_END) &&
		!chk_v_q && !v2_q && !v3_q;
	assign read_res  = (state_q == ppu_pkg::ST_READ) && v2_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_x_q <= '0;
			grav_y_q <= ppu_pkg::GRAVITY_Y_RST;
			grav_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				ppu_pkg::REG_GRAVITY_X: grav_x_q <= cfg_wdata;
				ppu_pkg::REG_GRAVITY_Y: grav_y_q <= cfg_wdata;
				ppu_pkg::REG_GRAVITY_Z: grav_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppu_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ppu_pkg::ST_CLEAR: begin
					if (cnt_q[AW-1:0] == ADDR_TOP) begin
						state_q <= ppu_pkg::ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ppu_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (op)
							ppu_pkg::OP_SPAWN: state_q <= ppu_pkg::ST_SPAWN;
							ppu_pkg::OP_TICK:  state_q <= ppu_pkg::ST_TICK;
							ppu_pkg::OP_READ: begin
								if (in_range) begin
									state_q <= ppu_pkg::ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ppu_pkg::ST_SPAWN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (spawn_res) begin
						state_q <= ppu_pkg::ST_IDLE;
					end
				end
				ppu_pkg::ST_TICK: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (tick_end) begin
						state_q <= ppu_pkg::ST_IDLE;
					end
				end
				ppu_pkg::ST_READ: begin
					if (read_res) begin
						state_q <= ppu_pkg::ST_IDLE;
					end
				end
				default: state_q <= ppu_pkg::ST_IDLE;
			endcase
		end
	end

	// Capture request fields; scale gravity by dt on every accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			spw_q.pos_x  <= pos_x;
			spw_q.pos_y  <= pos_y;
			spw_q.pos_z  <= pos_z;
			spw_q.vel_x  <= vel_x;
			spw_q.vel_y  <= vel_y;
			spw_q.vel_z  <= vel_z;
			spw_q.colors <= colors;
			spw_q.size   <= size;
			spw_q.life   <= life;
			dt_q         <= dt;
			gdt_x_q <= 25'((41'(grav_x_q) * $signed({25'd0, dt}) + 41'sd32768) >>> 16);
			gdt_y_q <= 25'((41'(grav_y_q) * $signed({25'd0, dt}) + 41'sd32768) >>> 16);
			gdt_z_q <= 25'((41'(grav_z_q) * $signed({25'd0, dt}) + 41'sd32768) >>> 16);
		end
	end

	// Read port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		case (state_q)
			ppu_pkg::ST_IDLE: begin
				rd_en   = accept && (op == ppu_pkg::OP_READ) && in_range;
				rd_addr = AW'(slot);
			end
			ppu_pkg::ST_SPAWN, ppu_pkg::ST_TICK: begin
				rd_en = (cnt_q < CNT_END);
			end
			default: ;
		endcase
	end

	// Write port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = word_s3;
		case (state_q)
			ppu_pkg::ST_CLEAR: begin
				wr_en        = 1'b1;
				wr_data      = '0;
				wr_data.life = ppu_pkg::LIFE_DEAD;
			end
			ppu_pkg::ST_SPAWN: begin
				wr_en   = found;
				wr_addr = chk_addr_q;
				wr_data = spw_q;
			end
			ppu_pkg::ST_TICK: begin
				wr_en   = v3_q;
				wr_addr = addr_s3;
				wr_data.pos_x = ppu_pkg::sat32(34'(word_s3.pos_x) +
					34'(33'((prod_x_s3 + 49'sd32768) >>> 16)));
				wr_data.pos_y = ppu_pkg::sat32(34'(word_s3.pos_y) +
					34'(33'((prod_y_s3 + 49'sd32768) >>> 16)));
				wr_data.pos_z = ppu_pkg::sat32(34'(word_s3.pos_z) +
					34'(33'((prod_z_s3 + 49'sd32768) >>> 16)));
				if (!live_s3) begin
					wr_data.pos_x = word_s3.pos_x;
					wr_data.pos_y = word_s3.pos_y;
					wr_data.pos_z = word_s3.pos_z;
				end
			end
			default: ;
		endcase
	end

	ppu_mem #(
		.DEPTH (POOL_SLOTS),
		.AW    (AW),
		.DW    (ppu_pkg::SLOT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	// Track which reads are in flight; drop them when a spawn ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_v_q <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
		end else begin
			chk_v_q <= rd_en && !spawn_res;
			v2_q    <= chk_v_q && ((state_q == ppu_pkg::ST_TICK) ||
				(state_q == ppu_pkg::ST_READ));
			v3_q    <= v2_q && (state_q == ppu_pkg::ST_TICK);
		end
	end

	// Stage 1: update velocity and life, form colour and alpha products
	logic signed [8:0]  dif_r, dif_g, dif_b;
	logic [16:0]        a_lin;
	ppu_pkg::slot_t     t1;
	logic               live1;
	always_comb begin
		live1  = (rw.life > 32'sd0);
		t1     = rw;
		if (live1) begin
			t1.vel_x = ppu_pkg::sat32(34'(rw.vel_x) + 34'(gdt_x_q));
			t1.vel_y = ppu_pkg::sat32(34'(rw.vel_y) + 34'(gdt_y_q));
			t1.vel_z = ppu_pkg::sat32(34'(rw.vel_z) + 34'(gdt_z_q));
		end
		t1.life = ppu_pkg::sat32(34'(rw.life) - $signed({18'd0, dt_q}));
		dif_r = $signed({1'b0, rw.colors[23:16]}) - $signed({1'b0, rw.colors[47:40]});
		dif_g = $signed({1'b0, rw.colors[15:8]})  - $signed({1'b0, rw.colors[39:32]});
		dif_b = $signed({1'b0, rw.colors[7:0]})   - $signed({1'b0, rw.colors[31:24]});
		a_lin = (rw.life > 32'sd65536) ? 17'd65536 : rw.life[16:0];
	end

	always_ff @(posedge clk) begin
		chk_addr_q <= rd_addr;
		addr_s2    <= chk_addr_q;
		live_s2    <= live1;
		word_s2    <= (state_q == ppu_pkg::ST_TICK) ? t1 : rw;
		prod_r_s2  <= 41'(dif_r) * 41'(rw.life);
		prod_g_s2  <= 41'(dif_g) * 41'(rw.life);
		prod_b_s2  <= 41'(dif_b) * 41'(rw.life);
		prod_a_s2  <= 25'(a_lin) * 25'd255;
	end

	// Stage 2: scale the new velocity by dt
	always_ff @(posedge clk) begin
		addr_s3   <= addr_s2;
		live_s3   <= live_s2;
		word_s3   <= word_s2;
		prod_x_s3 <= 49'(word_s2.vel_x) * $signed({33'd0, dt_q});
		prod_y_s3 <= 49'(word_s2.vel_y) * $signed({33'd0, dt_q});
		prod_z_s3 <= 49'(word_s2.vel_z) * $signed({33'd0, dt_q});
	end

	// Colour channel: start plus rounded product, clamped to a byte
	function automatic logic [7:0] chan(input logic [7:0] s, input logic signed [40:0] p);
		logic signed [25:0] c;
		logic [7:0]         r;
		c = $signed({18'd0, s}) + 26'(25'((p + 41'sd32768) >>> 16));
		if (c < 26'sd0) begin
			r = 8'd0;
		end else if (c > 26'sd255) begin
			r = 8'd255;
		end else begin
			r = c[7:0];
		end
		return r;
	endfunction

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= idle_zero || spawn_res || tick_end || read_res;
		end
	end

	// Result fields, zero outside a result
	always_ff @(posedge clk) begin
		accepted  <= 1'b0;
		alive     <= 1'b0;
		out_pos_x <= '0;
		out_pos_y <= '0;
		out_pos_z <= '0;
		out_size  <= '0;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		alpha     <= '0;
		if (spawn_res) begin
			accepted <= found;
		end
		if (read_res) begin
			out_pos_x <= word_s2.pos_x;
			out_pos_y <= word_s2.pos_y;
			out_pos_z <= word_s2.pos_z;
			out_size  <= word_s2.size;
			if (live_s2) begin
				alive <= 1'b1;
				red   <= chan(word_s2.colors[47:40], prod_r_s2);
				green <= chan(word_s2.colors[39:32], prod_g_s2);
				blue  <= chan(word_s2.colors[31:24], prod_b_s2);
				alpha <= 8'((prod_a_s2 + 25'd32768) >> 16);
			end
		end
	end

endmodule

@@ rtl/ppu_check.sv @@
module ppu_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         opcode,
	input logic               done,
	input logic               accepted,
	input logic               alive,
	input logic signed [31:0] out_pos_x,
	input logic [15:0]        out_size,
	input logic [7:0]         red,
	input logic [7:0]         green,
	input logic [7:0]         blue,
	input logic [7:0]         alpha
);

	// A tick always occupies the block
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == ppu_pkg::OP_TICK) |=> busy)
		else $error("tick request did not raise busy");

	// Result fields stay quiet between strobes
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (!accepted && !alive && alpha == 8'd0 && out_size == 16'd0))
		else $error("result field active without strobe");

	// A dead slot reports no colour
	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !alive) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0))
		else $error("colour reported for a dead slot");

	// Spawn and read answers never mix
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(accepted && alive))
		else $error("accepted and alive both set");

endmodule

bind particle_pool_update ppu_check u_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int SLOTS = 1024;

	typedef enum logic [1:0] {
		KIND_REQ,
		KIND_CFG,
		KIND_DRAIN
	} kind_t;

	typedef struct {
		kind_t              kind;
		ppu_pkg::op_t       op;
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic [47:0]        colors;
		logic [15:0]        size;
		logic signed [31:0] life;
		logic [15:0]        dt;
		logic [9:0]         slot;
		logic [1:0]         cfg_idx;
		logic [23:0]        cfg_val;
	} pending_t;

	typedef struct {
		logic               accepted;
		logic               alive;
		logic signed [31:0] px, py, pz;
		logic [15:0]        size;
		logic [7:0]         red, green, blue, alpha;
	} render_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [23:0] cfg_wdata = '0;
	pending_t cur = '{kind: KIND_REQ, op: ppu_pkg::OP_NONE, default: '0};

	logic accepted, alive;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic [15:0] out_size;
	logic [7:0] red, green, blue, alpha;

	// Pool mirror and gravity registers
	int pool_px[SLOTS], pool_py[SLOTS], pool_pz[SLOTS];
	int pool_vx[SLOTS], pool_vy[SLOTS], pool_vz[SLOTS];
	logic [47:0] pool_col[SLOTS];
	logic [15:0] pool_size[SLOTS];
	int pool_life[SLOTS];
	int grav_x, grav_y, grav_z;

	pending_t pending[$];
	render_t expected_renders[$];
	int errors = 0;
	int checked = 0;
	int issued[4] = '{0, 0, 0, 0};
	logic req_taken = 1'b0;
	int gap_cnt = 0;
	int settle_cnt = 0;
	int burst_left = 4;

	particle_pool_update DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(cur.op), .pos_x(cur.px), .pos_y(cur.py), .pos_z(cur.pz),
		.vel_x(cur.vx), .vel_y(cur.vy), .vel_z(cur.vz), .colors(cur.colors),
		.size(cur.size), .life(cur.life), .dt(cur.dt), .slot(cur.slot),
		.done(done), .accepted(accepted), .alive(alive),
		.out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
		.out_size(out_size), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint round_q16(longint x);
		return (x + 32768) >>> 16;
	endfunction

	function automatic int clip32(longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (x < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return int'(x);
	endfunction

	function automatic logic [7:0] fade_channel(logic [47:0] col, int life, int shift);
		longint s, e, c;
		s = longint'((col >> (24 + shift)) & 48'hFF);
		e = longint'((col >> shift) & 48'hFF);
		c = s + round_q16((e - s) * longint'(life));
		if (c < 0) begin
			c = 0;
		end
		if (c > 255) begin
			c = 255;
		end
		return c[7:0];
	endfunction

	// Apply one request to the pool mirror and form its render record
	function automatic render_t pool_step(pending_t p);
		render_t r;
		longint d, gx, gy, gz, a;
		int i;
		r = '{default: '0};
		case (p.op)
			ppu_pkg::OP_SPAWN: begin
				for (i = 0; i < SLOTS; i++) begin
					if (pool_life[i] <= 0) begin
						pool_px[i] = p.px; pool_py[i] = p.py; pool_pz[i] = p.pz;
						pool_vx[i] = p.vx; pool_vy[i] = p.vy; pool_vz[i] = p.vz;
						pool_col[i] = p.colors;
						pool_size[i] = p.size;
						pool_life[i] = p.life;
						r.accepted = 1'b1;
						break;
					end
				end
			end
			ppu_pkg::OP_TICK: begin
				d = longint'(p.dt);
				gx = round_q16(longint'(grav_x) * d);
				gy = round_q16(longint'(grav_y) * d);
				gz = round_q16(longint'(grav_z) * d);
				for (i = 0; i < SLOTS; i++) begin
					if (pool_life[i] > 0) begin
						pool_vx[i] = clip32(longint'(pool_vx[i]) + gx);
						pool_vy[i] = clip32(longint'(pool_vy[i]) + gy);
						pool_vz[i] = clip32(longint'(pool_vz[i]) + gz);
						pool_px[i] = clip32(longint'(pool_px[i])
							+ round_q16(longint'(pool_vx[i]) * d));
						pool_py[i] = clip32(longint'(pool_py[i])
							+ round_q16(longint'(pool_vy[i]) * d));
						pool_pz[i] = clip32(longint'(pool_pz[i])
							+ round_q16(longint'(pool_vz[i]) * d));
					end
					pool_life[i] = clip32(longint'(pool_life[i]) - d);
				end
			end
			ppu_pkg::OP_READ: begin
				i = int'(p.slot);
				r.px = pool_px[i]; r.py = pool_py[i]; r.pz = pool_pz[i];
				r.size = pool_size[i];
				if (pool_life[i] > 0) begin
					a = (pool_life[i] > 65536) ? 65536 : longint'(pool_life[i]);
					r.alive = 1'b1;
					r.red = fade_channel(pool_col[i], pool_life[i], 16);
					r.green = fade_channel(pool_col[i], pool_life[i], 8);
					r.blue = fade_channel(pool_col[i], pool_life[i], 0);
					a = (a * 255 + 32768) >>> 16;
					r.alpha = a[7:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic compare_field(string name, longint e, longint a);
		if (e != a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
		end
	endtask

	// Accept requests, predict, and check each result against the oldest expectation
	always @(posedge clk) begin
		render_t e;
		if (arst_n && cfg_we) begin
			case (cfg_addr)
				ppu_pkg::REG_GRAVITY_X: grav_x = int'($signed(cfg_wdata));
				ppu_pkg::REG_GRAVITY_Y: grav_y = int'($signed(cfg_wdata));
				ppu_pkg::REG_GRAVITY_Z: grav_z = int'($signed(cfg_wdata));
				default: ;
			endcase
		end
		if (arst_n && done) begin
			if (expected_renders.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual done", $time);
			end else begin
				e = expected_renders.pop_front();
				checked++;
				compare_field("accepted", e.accepted, accepted);
				compare_field("alive", e.alive, alive);
				compare_field("out_pos_x", e.px, out_pos_x);
				compare_field("out_pos_y", e.py, out_pos_y);
				compare_field("out_pos_z", e.pz, out_pos_z);
				compare_field("out_size", e.size, out_size);
				compare_field("red", e.red, red);
				compare_field("green", e.green, green);
				compare_field("blue", e.blue, blue);
				compare_field("alpha", e.alpha, alpha);
			end
		end
		if (arst_n && start && !busy) begin
			expected_renders.push_back(pool_step(cur));
			issued[cur.op]++;
		end
		req_taken <= arst_n && start && !busy;
	end

	// Drive requests and register writes from the pending queue
	always @(negedge clk) begin
		logic start_n, we_n;
		pending_t nxt;
		start_n = start;
		we_n = 1'b0;
		nxt = cur;
		if (arst_n && !(start && !req_taken)) begin
			start_n = 1'b0;
			if (gap_cnt > 0) begin
				gap_cnt--;
			end else if (settle_cnt > 0) begin
				settle_cnt--;
			end else if (pending.size() > 0) begin
				case (pending[0].kind)
					KIND_REQ: begin
						nxt = pending.pop_front();
						start_n = 1'b1;
						burst_left--;
						if (burst_left <= 0) begin
							burst_left = $urandom_range(1, 20);
							gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						end
					end
					KIND_DRAIN: begin
						if (expected_renders.size() == 0 && !busy) begin
							void'(pending.pop_front());
							settle_cnt = 8;
						end
					end
					default: begin
						nxt = pending.pop_front();
						we_n = 1'b1;
					end
				endcase
			end
		end
		start <= start_n;
		cur <= nxt;
		cfg_we <= we_n;
		cfg_addr <= nxt.cfg_idx;
		cfg_wdata <= nxt.cfg_val;
	end

	function automatic pending_t random_request(ppu_pkg::op_t op);
		pending_t p;
		p = '{kind: KIND_REQ, op: op, default: '0};
		p.px = $urandom(); p.py = $urandom(); p.pz = $urandom();
		if ($urandom_range(0, 3) != 0) begin
			p.vx = $signed($urandom_range(0, 2 * 655360)) - 655360;
			p.vy = $signed($urandom_range(0, 2 * 655360)) - 655360;
			p.vz = $signed($urandom_range(0, 2 * 655360)) - 655360;
		end else begin
			p.vx = $urandom(); p.vy = $urandom(); p.vz = $urandom();
		end
		p.colors = 48'({$urandom(), $urandom()});
		p.size = 16'($urandom());
		case ($urandom_range(0, 9))
			0: p.life = $urandom();
			1: p.life = -$signed($urandom_range(0, 100000));
			default: p.life = $urandom_range(1, 4 * 65536);
		endcase
		p.dt = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8000));
		p.slot = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 40));
		return p;
	endfunction

	function automatic ppu_pkg::op_t random_op();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6: return ppu_pkg::OP_SPAWN;
			7, 8, 9, 10: return ppu_pkg::OP_TICK;
			19: return ppu_pkg::OP_NONE;
			default: return ppu_pkg::OP_READ;
		endcase
	endfunction

	task automatic add_config(logic [1:0] idx, logic [23:0] val);
		pending_t p;
		p = '{kind: KIND_CFG, op: ppu_pkg::OP_NONE, default: '0};
		p.cfg_idx = idx;
		p.cfg_val = val;
		pending.push_back(p);
	endtask

	task automatic add_drain();
		pending_t p;
		p = '{kind: KIND_DRAIN, op: ppu_pkg::OP_NONE, default: '0};
		pending.push_back(p);
	endtask

	// Build the stimulus, release reset and wait for the last result
	initial begin
		pending_t p;
		int k;
		for (k = 0; k < SLOTS; k++) begin
			pool_px[k] = 0; pool_py[k] = 0; pool_pz[k] = 0;
			pool_vx[k] = 0; pool_vy[k] = 0; pool_vz[k] = 0;
			pool_col[k] = '0; pool_size[k] = '0; pool_life[k] = ppu_pkg::LIFE_DEAD;
		end
		grav_x = 0;
		grav_y = ppu_pkg::GRAVITY_Y_RST;
		grav_z = 0;

		// Directed: reads at reset, unknown opcode, field extremes
		p = random_request(ppu_pkg::OP_READ); p.slot = 10'd0; pending.push_back(p);
		p.slot = 10'd1023; pending.push_back(p);
		pending.push_back(random_request(ppu_pkg::OP_NONE));
		p = random_request(ppu_pkg::OP_SPAWN);
		p.px = 32'sh7FFF_FFFF; p.py = 32'sh8000_0000; p.pz = 0;
		p.vx = 32'sh7FFF_FFFF; p.vy = 32'sh8000_0000; p.vz = -1;
		p.colors = 48'hFFFFFF_000000; p.size = 16'hFFFF; p.life = 32'sh7FFF_FFFF;
		pending.push_back(p);
		p = random_request(ppu_pkg::OP_SPAWN); p.life = 0; p.colors = 48'h0; p.size = 0;
		pending.push_back(p);
		p = random_request(ppu_pkg::OP_SPAWN); p.life = 32'sh8000_0000; pending.push_back(p);
		p = random_request(ppu_pkg::OP_SPAWN); p.life = 32768; p.colors = 48'h00FF80_FF00FF;
		pending.push_back(p);
		p = random_request(ppu_pkg::OP_READ); p.slot = 10'd1; pending.push_back(p);
		p = random_request(ppu_pkg::OP_TICK); p.dt = 16'hFFFF; pending.push_back(p);
		p = random_request(ppu_pkg::OP_TICK); p.dt = 16'h0000; pending.push_back(p);
		for (k = 0; k < 4; k++) begin
			p = random_request(ppu_pkg::OP_READ); p.slot = 10'(k); pending.push_back(p);
		end
		add_drain();
		add_config(ppu_pkg::REG_GRAVITY_X, 24'h7FFFFF);
		add_config(ppu_pkg::REG_GRAVITY_Y, 24'h800000);
		add_config(ppu_pkg::REG_GRAVITY_Z, 24'h7FFFFF);
		add_config(2'd3, 24'h123456);
		p = random_request(ppu_pkg::OP_TICK); p.dt = 16'hFFFF; pending.push_back(p);
		p = random_request(ppu_pkg::OP_READ); p.slot = 10'd0; pending.push_back(p);

		// Random phases under different gravity settings
		for (k = 0; k < 560; k++) begin
			if (k % 140 == 0) begin
				add_drain();
				case (k / 140)
					0: begin
						add_config(ppu_pkg::REG_GRAVITY_X, 24'h800000);
						add_config(ppu_pkg::REG_GRAVITY_Y, 24'h7FFFFF);
						add_config(ppu_pkg::REG_GRAVITY_Z, 24'h800000);
					end
					1: begin
						add_config(ppu_pkg::REG_GRAVITY_X, 24'($urandom()));
						add_config(ppu_pkg::REG_GRAVITY_Y, 24'($urandom()));
						add_config(ppu_pkg::REG_GRAVITY_Z, 24'($urandom()));
					end
					2: begin
						add_config(ppu_pkg::REG_GRAVITY_X, 24'h0);
						add_config(ppu_pkg::REG_GRAVITY_Y, 24'h0);
						add_config(ppu_pkg::REG_GRAVITY_Z, 24'h0);
					end
					default: begin
						add_config(ppu_pkg::REG_GRAVITY_X, 24'h000000);
						add_config(ppu_pkg::REG_GRAVITY_Y, ppu_pkg::GRAVITY_Y_RST);
						add_config(ppu_pkg::REG_GRAVITY_Z, 24'h00FFFF);
					end
				endcase
			end
			pending.push_back(random_request(random_op()));
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending.size() > 0 || start || expected_renders.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (expected_renders.size() > 0) begin
			errors++;
		end
		$display("Requests: %0d spawn, %0d tick, %0d read, %0d unknown; %0d results checked",
			issued[0], issued[1], issued[2], issued[3], checked);
		$display("Gravity swept through both extremes, zero and random values");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#100_000_000;
		$display("Timeout with %0d results outstanding", expected_renders.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ppu_pkg.sv
rtl/ppu_mem.sv
rtl/particle_pool_update.sv
rtl/ppu_check.sv
tb/testbench.sv
